>>> hw/rtl/mpd_pkg.sv
// Package for the mouse packet deframer: constants, defaults and the
// packet record passed from the front end to the back end. No dependencies.
`default_nettype none
package mpd_pkg;

	localparam logic [7:0] HDR_RESET        = 8'hAA;
	localparam logic [7:0] BTN_MASK         = 8'h07;
	localparam logic [7:0] WHEEL_FLAG       = 8'h08;
	localparam int         PACKET_LEN       = 6;
	localparam logic [2:0] POS_HUNT         = 3'd0;
	localparam logic [2:0] POS_FLAGS        = 3'd1;
	localparam logic [2:0] POS_DX           = 3'd2;
	localparam logic [2:0] POS_DY           = 3'd3;
	localparam logic [2:0] POS_WHEEL        = 3'd4;
	localparam logic [2:0] POS_CHECK        = 3'(PACKET_LEN - 1);
	localparam int         COUNTER_BITS_DEF = 32;
	localparam int         OUT_CNT_BITS     = 32;
	localparam int         QUEUE_DEPTH      = 2;

	typedef struct packed {
		logic              good;
		logic [2:0]        buttons;
		logic signed [7:0] dx;
		logic signed [7:0] dy;
		logic signed [7:0] wheel;
	} pkt_t;

endpackage
`default_nettype wire

>>> hw/rtl/mpd_byte_if.sv
// Byte stream channel: valid, ready and one stream byte.
// Depends on nothing.
`default_nettype none
interface mpd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source(output valid, output byte_in, input ready);
	modport sink(input valid, input byte_in, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/mpd_res_if.sv
// Result channel: valid, ready and the decoded packet fields with counters.
// Depends on nothing.
`default_nettype none
interface mpd_res_if;
	logic              valid;
	logic              ready;
	logic              status;
	logic [2:0]        buttons;
	logic signed [7:0] move_x;
	logic signed [7:0] move_y;
	logic signed [7:0] wheel_step;
	logic [31:0]       good_count;
	logic [31:0]       bad_count;

	modport source(output valid, output status, output buttons, output move_x,
		output move_y, output wheel_step, output good_count, output bad_count,
		input ready);
	modport sink(input valid, input status, input buttons, input move_x,
		input move_y, input wheel_step, input good_count, input bad_count,
		output ready);
endinterface
`default_nettype wire

>>> hw/rtl/mpd_front.sv
// Front end: header hunt, field capture, running XOR and checksum check.
// Depends on mpd_pkg and mpd_byte_if.
`default_nettype none
module mpd_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_data,
	mpd_byte_if.sink         rx,
	input  wire logic        q_full,
	output logic             q_push,
	output mpd_pkg::pkt_t    q_din
);
	import mpd_pkg::*;

	logic [2:0] pos_q;
	logic [7:0] xor_q;
	logic [7:0] header_q;
	logic [7:0] flags_q;
	logic [7:0] dx_q;
	logic [7:0] dy_q;
	logic [7:0] wheel_q;
	logic       accept;
	logic       good;

	assign rx.ready = !((pos_q == POS_CHECK) && q_full);
	assign accept   = rx.valid && rx.ready;
	assign good     = (rx.byte_in == xor_q);
	assign q_push   = accept && (pos_q == POS_CHECK);

	always_comb begin
		q_din.good    = good;
		q_din.buttons = good ? 3'(flags_q & BTN_MASK) : 3'd0;
		q_din.dx      = good ? dx_q : 8'sd0;
		q_din.dy      = good ? dy_q : 8'sd0;
		q_din.wheel   = (good && ((flags_q & WHEEL_FLAG) != 8'd0)) ? wheel_q : 8'sd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HDR_RESET;
		end else if (cfg_we) begin
			header_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
			xor_q <= 8'd0;
		end else if (accept) begin
			priority if (pos_q == POS_HUNT) begin
				if (rx.byte_in == header_q) begin
					xor_q <= rx.byte_in;
					pos_q <= POS_FLAGS;
				end
			end else if (pos_q < POS_CHECK) begin
				xor_q <= xor_q ^ rx.byte_in;
				pos_q <= pos_q + 3'd1;
			end else begin
				pos_q <= POS_HUNT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (pos_q)
				POS_FLAGS: flags_q <= rx.byte_in;
				POS_DX:    dx_q    <= rx.byte_in;
				POS_DY:    dy_q    <= rx.byte_in;
				POS_WHEEL: wheel_q <= rx.byte_in;
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_CHECK)
		else $error("byte position beyond checksum slot");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/mpd_queue.sv
// Short queue of packet records between the front end and the back end.
// Depends on mpd_pkg.
`default_nettype none
module mpd_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mpd_pkg::pkt_t  din,
	output logic                full,
	input  wire logic           pop,
	output logic                valid,
	output mpd_pkg::pkt_t       dout
);
	import mpd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	pkt_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign valid   = (cnt_q != '0);
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("request pushed into a full queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/mpd_back.sv
// Back end: packet counters and the registered result stage.
// Depends on mpd_pkg and mpd_res_if.
`default_nettype none
module mpd_back #(
	parameter int COUNTER_BITS = mpd_pkg::COUNTER_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire mpd_pkg::pkt_t  q_dout,
	output logic                q_pop,
	mpd_res_if.source           res
);
	import mpd_pkg::*;

	logic [COUNTER_BITS-1:0] good_q;
	logic [COUNTER_BITS-1:0] bad_q;
	logic [COUNTER_BITS-1:0] good_nxt;
	logic [COUNTER_BITS-1:0] bad_nxt;
	logic [63:0]             good_ext;
	logic [63:0]             bad_ext;
	logic                    out_valid_q;
	pkt_t                    out_pkt_q;
	logic [OUT_CNT_BITS-1:0] out_good_q;
	logic [OUT_CNT_BITS-1:0] out_bad_q;

	assign q_pop    = q_valid && (!out_valid_q || res.ready);
	assign good_nxt = good_q + COUNTER_BITS'(q_dout.good);
	assign bad_nxt  = bad_q + COUNTER_BITS'(!q_dout.good);
	assign good_ext = 64'(good_nxt);
	assign bad_ext  = 64'(bad_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_q      <= '0;
			bad_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				good_q      <= good_nxt;
				bad_q       <= bad_nxt;
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_pkt_q  <= q_dout;
			out_good_q <= good_ext[OUT_CNT_BITS-1:0];
			out_bad_q  <= bad_ext[OUT_CNT_BITS-1:0];
		end
	end

	assign res.valid      = out_valid_q;
	assign res.status     = !out_pkt_q.good;
	assign res.buttons    = out_pkt_q.buttons;
	assign res.move_x     = out_pkt_q.dx;
	assign res.move_y     = out_pkt_q.dy;
	assign res.wheel_step = out_pkt_q.wheel;
	assign res.good_count = out_good_q;
	assign res.bad_count  = out_bad_q;

`ifndef SYNTHESIS
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!q_pop |=> ($stable(good_q) && $stable(bad_q)))
		else $error("packet counter moved without a request");
	a_one_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> ($stable(good_q) != $stable(bad_q)))
		else $error("a request must advance exactly one counter");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/mouse_packet_deframer.sv
// Top level of the mouse packet deframer: front end, queue and back end.
// Depends on mpd_pkg, mpd_byte_if, mpd_res_if, mpd_front, mpd_queue, mpd_back.
//
//  channel  dir  handshake     payload
//  rx       in   valid/ready   byte_in
//  res      out  valid/ready   status, buttons, move_x, move_y, wheel_step,
//                              good_count, bad_count
//  cfg      in   cfg_we        cfg_data (header byte)
//
// One byte is taken every cycle unless stalled; position and XOR update with each byte.
// A result is queued, then registered in the result stage, and is held until taken.
// A two-entry queue lets the front keep taking bytes while results are stalled.
// Only the checksum byte can stall input, when the queue is full.
// Reset clears position, XOR, counters and the queue; the header byte resets to 0xAA.
`default_nettype none
module mouse_packet_deframer #(
	parameter int COUNTER_BITS = mpd_pkg::COUNTER_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_data,
	mpd_byte_if.sink        rx,
	mpd_res_if.source       res
);
	import mpd_pkg::*;

	pkt_t q_din;
	pkt_t q_dout;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_valid;

	mpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.rx       (rx),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_din    (q_din)
	);

	mpd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.dout   (q_dout)
	);

	mpd_back #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_dout  (q_dout),
		.q_pop   (q_pop),
		.res     (res)
	);

endmodule
`default_nettype wire
